[hw/rtl/fwdqt_pkg.sv]
// ----------------------------------------------------------------------------
// fwdqt_pkg
// Types and constants shared by the 4WD / quick turn controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fwdqt_pkg;

  // fixed timing constants in milliseconds
  localparam logic [15:0] QT_BLOCK_RELEASE_MS = 16'd300;
  localparam logic [15:0] HOLD_MS             = 16'd100;
  localparam logic [15:0] RECONNECT_MS        = 16'd200;
  localparam logic [15:0] TICK_MS             = 16'd10;

  // panel drive modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_QT_CUTOUT_SPEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AWD_CUTOUT_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AWD_RECONNECT_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QT_ENGAGE_MS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_ON_MS          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_CYCLE_MS       = 3'd5;

  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic [11:0] qt_cutout_speed;
    logic [11:0] awd_cutout_speed;
    logic [11:0] awd_reconnect_speed;
    logic [13:0] qt_engage_ms;
    logic [13:0] lamp_on_ms;
    logic [13:0] lamp_cycle_ms;
  } cfg_t;

  typedef struct packed {
    logic [11:0] vehicle_speed;
    logic        reversing;
    logic        steering_turned;
    logic        side_brake;
    logic        brake_pedal;
    logic        qt_value;
    logic        qt_write;
    logic [1:0]  drive_mode;
    logic        power_ready;
    logic        tick_10ms;
  } req_t;

  typedef struct packed {
    logic speed_limited;
    logic qt_active;
    logic qt_cancelled;
    logic qt_flashing;
    logic qt_lamp;
    logic awd_lamp;
    logic qt_valve;
    logic awd_valve;
  } res_t;

  typedef struct packed {
    logic        qt_enabled;
    logic        qt_speed_block;
    logic [15:0] qt_block_timer;
    logic [15:0] steer_hold_timer;
    logic [15:0] qt_run_timer;
    logic [15:0] awd_holdoff_timer;
    logic [15:0] brake_hold_timer;
    logic [15:0] reconnect_timer;
    logic [15:0] lamp_blink_timer;
    logic        speed_limit_flag;
    logic        flash_flag;
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/fwdqt_step.sv]
// ----------------------------------------------------------------------------
// fwdqt_step
// One control step: next controller state and result from the current
// state, the configuration and one request.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdqt_step
  import fwdqt_pkg::*;
(
  input  state_t state,
  input  cfg_t   cfg,
  input  req_t   req,
  output state_t state_next,
  output res_t   res
);

  state_t      s;
  logic        awd_v;
  logic        qt_v;
  logic        awd_l;
  logic        qt_l;
  logic        cancel;
  logic        ready;
  logic        go_auto;
  logic        tick;
  logic [15:0] speed;

  always_comb begin
    s       = state;
    awd_v   = 1'b0;
    qt_v    = 1'b0;
    awd_l   = 1'b0;
    qt_l    = 1'b0;
    cancel  = 1'b0;
    ready   = 1'b0;
    go_auto = 1'b0;
    tick    = req.tick_10ms;
    speed   = {4'd0, req.vehicle_speed};

    // panel write comes first
    if (req.qt_write) begin
      s.qt_enabled = req.qt_value;
    end

    if (!req.power_ready) begin
      s.qt_enabled        = 1'b0;
      s.awd_holdoff_timer = '0;
    end else begin
      // quick turn speed block with release delay
      if ({4'd0, cfg.qt_cutout_speed} <= speed) begin
        s.qt_speed_block = 1'b1;
        s.qt_block_timer = '0;
      end else if (s.qt_block_timer >= QT_BLOCK_RELEASE_MS) begin
        s.qt_speed_block = 1'b0;
      end else if (tick) begin
        s.qt_block_timer = s.qt_block_timer + TICK_MS;
      end

      if (req.drive_mode == MODE_OFF) begin
        // off mode: brake hold engages 4wd
        s.lamp_blink_timer = '0;
        s.flash_flag       = 1'b0;
        s.qt_run_timer     = '0;
        s.speed_limit_flag = 1'b0;
        s.qt_enabled       = 1'b0;
        if (!req.brake_pedal || req.side_brake) begin
          s.brake_hold_timer = '0;
        end else if (s.brake_hold_timer <= HOLD_MS) begin
          if (tick) begin
            s.brake_hold_timer = s.brake_hold_timer + TICK_MS;
          end
        end else begin
          awd_v = 1'b1;
        end
      end else if (s.qt_enabled) begin
        // quick turn enabled: steering hold then engage delay
        qt_l = 1'b1;
        if (req.steering_turned && !req.reversing) begin
          if (s.steer_hold_timer <= HOLD_MS) begin
            if (tick) begin
              s.steer_hold_timer = s.steer_hold_timer + TICK_MS;
            end
          end else begin
            ready = 1'b1;
          end
        end else begin
          s.steer_hold_timer = '0;
        end
        if (ready && s.qt_speed_block) begin
          cancel       = 1'b1;
          s.qt_enabled = 1'b0;
          ready        = 1'b0;
        end
        if (ready) begin
          if (tick) begin
            s.qt_run_timer = s.qt_run_timer + TICK_MS;
          end
          if (s.qt_run_timer >= {2'd0, cfg.qt_engage_ms}) begin
            s.qt_run_timer      = {2'd0, cfg.qt_engage_ms};
            s.awd_holdoff_timer = {2'd0, cfg.qt_engage_ms};
            qt_v                = 1'b1;
            s.flash_flag        = 1'b1;
          end
        end else begin
          s.qt_run_timer = '0;
          go_auto        = 1'b1;
        end
      end else if (req.drive_mode == MODE_MANUAL) begin
        awd_v = 1'b1;
      end else begin
        go_auto = 1'b1;
      end

      // auto mode section
      if (go_auto) begin
        if (!s.qt_enabled) begin
          s.awd_holdoff_timer = '0;
        end
        if (!qt_l) begin
          awd_l = 1'b1;
        end
        if (s.awd_holdoff_timer != '0) begin
          // hold-off countdown, saturating at zero
          if (tick) begin
            s.awd_holdoff_timer = (s.awd_holdoff_timer > TICK_MS) ?
                                  s.awd_holdoff_timer - TICK_MS : '0;
          end
        end else begin
          awd_v        = 1'b1;
          s.flash_flag = 1'b0;

          // speed cutout and reconnect
          if ({4'd0, cfg.awd_cutout_speed} <= speed) begin
            s.speed_limit_flag = 1'b1;
            s.reconnect_timer  = '0;
          end else if (s.speed_limit_flag) begin
            if ({4'd0, cfg.awd_reconnect_speed} >= speed) begin
              if (tick) begin
                s.reconnect_timer = s.reconnect_timer + TICK_MS;
              end
              if (s.reconnect_timer >= RECONNECT_MS) begin
                s.speed_limit_flag = 1'b0;
              end
            end else begin
              s.reconnect_timer = '0;
            end
          end

          if (tick) begin
            s.lamp_blink_timer = s.lamp_blink_timer + TICK_MS;
          end

          // lamp blink while speed limited
          if (s.speed_limit_flag) begin
            awd_v = 1'b0;
            if (awd_l) begin
              if (s.lamp_blink_timer >= {2'd0, cfg.lamp_on_ms}) begin
                awd_l = 1'b0;
              end else begin
                s.lamp_blink_timer = '0;
              end
            end
          end else begin
            s.lamp_blink_timer = '0;
          end

          if (s.lamp_blink_timer >= {2'd0, cfg.lamp_cycle_ms}) begin
            s.lamp_blink_timer = '0;
          end
        end
      end
    end
  end

  assign state_next        = s;
  assign res.awd_valve     = awd_v;
  assign res.qt_valve      = qt_v;
  assign res.awd_lamp      = awd_l;
  assign res.qt_lamp       = qt_l;
  assign res.qt_flashing   = s.flash_flag;
  assign res.qt_cancelled  = cancel;
  assign res.qt_active     = s.qt_enabled;
  assign res.speed_limited = s.speed_limit_flag;

endmodule

`default_nettype wire

[hw/rtl/four_wheel_drive_quick_turn_ctrl.sv]
// Each result is registered, valid the cycle after its request is accepted.
// Throughput: one request per clock while m_tready is high; the result
// register frees in the same cycle it is taken, so s_tready stays high.
// Each step is one pass through the step logic between the state registers.
// Reset (rst, synchronous): all timers and flags clear, configuration takes
// its default values, no result is pending.
`default_nettype none

module four_wheel_drive_quick_turn_ctrl
  import fwdqt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // tick_10ms, power_ready, drive_mode[1:0], qt_write, qt_value, brake_pedal,
  // side_brake, steering_turned, reversing, vehicle_speed[11:0], zero pad[1:0]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // awd_valve, qt_valve, awd_lamp, qt_lamp, qt_flashing, qt_cancelled,
  // qt_active, speed_limited
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  req_t   req;
  res_t   res;
  logic   s_fire;

  assign req      = req_t'(s_tdata[IN_DATA_W-3:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qt_cutout_speed     <= 12'd100;
      cfg.awd_cutout_speed    <= 12'd150;
      cfg.awd_reconnect_speed <= 12'd120;
      cfg.qt_engage_ms        <= 14'd500;
      cfg.lamp_on_ms          <= 14'd500;
      cfg.lamp_cycle_ms       <= 14'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_QT_CUTOUT_SPEED:     cfg.qt_cutout_speed     <= cfg_data[11:0];
        REG_AWD_CUTOUT_SPEED:    cfg.awd_cutout_speed    <= cfg_data[11:0];
        REG_AWD_RECONNECT_SPEED: cfg.awd_reconnect_speed <= cfg_data[11:0];
        REG_QT_ENGAGE_MS:        cfg.qt_engage_ms        <= cfg_data;
        REG_LAMP_ON_MS:          cfg.lamp_on_ms          <= cfg_data;
        REG_LAMP_CYCLE_MS:       cfg.lamp_cycle_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // step logic
  fwdqt_step u_step (
    .state      (state),
    .cfg        (cfg),
    .req        (req),
    .state_next (state_next),
    .res        (res)
  );

  // controller state, updated once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= res;
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// four_wheel_drive_quick_turn_ctrl testbench
// Drives control-step requests into the 4WD / quick turn controller with
// random idling on both stream sides and checks every result against an
// in-bench model or a typed row's expected value. Runs a short directed table under
// reset settings, then random bursts of brake holds, quick turn sequences,
// auto-mode speed sweeps and noise over several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import fwdqt_pkg::*;

  // auto mode and the unused panel code that behaves like it
  localparam logic [1:0] MODE_AUTO = 2'd2;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  localparam res_t OUT_NONE = 8'h00;
  localparam res_t OUT_AWD  = 8'h01;  // 4WD valve alone

  localparam int unsigned RAND_PER_PHASE = 330;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned HOLD_AT        = 100;
  localparam int unsigned PAUSE_AT       = 220;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned CYCLE_LIMIT    = 1500000;

  typedef struct packed {
    req_t       req;
    logic [7:0] reps;
    logic       typed;
    res_t       want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  bit          hold_ask = 1'b0;
  res_t        pending_outs [$];
  step_row_t   step_table [$];
  string       out_field [8] = '{"awd_valve", "qt_valve", "awd_lamp", "qt_lamp",
                                 "qt_flashing", "qt_cancelled", "qt_active",
                                 "speed_limited"};

  // controller model state
  cfg_t        cur_cfg;
  logic        qt_en, qt_blk, limit_on, flash_on;
  logic [15:0] blk_tmr, steer_tmr, run_tmr, holdoff_tmr, brake_tmr, recon_tmr, blink_tmr;
  res_t        step_out;

  four_wheel_drive_quick_turn_ctrl u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("four_wheel_drive_quick_turn_ctrl test failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none in steady windows
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // speed close to one of the thresholds, or an extreme
  function automatic logic [11:0] near_speed();
    int v;
    case ($urandom_range(0, 5))
      0: v = cur_cfg.qt_cutout_speed;
      1: v = cur_cfg.awd_cutout_speed;
      2: v = cur_cfg.awd_reconnect_speed;
      3: v = 0;
      4: v = 4095;
      default: return $urandom_range(0, 4095);
    endcase
    v = v + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // one control step with power present
  function automatic void step_body(input req_t r);
    logic ready;
    ready = 1'b0;
    // quick turn speed block with release delay
    if (cur_cfg.qt_cutout_speed <= r.vehicle_speed) begin
      qt_blk  = 1'b1;
      blk_tmr = '0;
    end else if (blk_tmr >= QT_BLOCK_RELEASE_MS) begin
      qt_blk = 1'b0;
    end else if (r.tick_10ms) begin
      blk_tmr = blk_tmr + TICK_MS;
    end

    if (r.drive_mode == MODE_OFF) begin
      blink_tmr = '0;
      flash_on  = 1'b0;
      run_tmr   = '0;
      limit_on  = 1'b0;
      qt_en     = 1'b0;
      if (!r.brake_pedal || r.side_brake) begin
        brake_tmr = '0;
        return;
      end
      if (brake_tmr <= HOLD_MS) begin
        if (r.tick_10ms) brake_tmr = brake_tmr + TICK_MS;
        return;
      end
      step_out.awd_valve = 1'b1;
      return;
    end else if (qt_en) begin
      step_out.qt_lamp  = 1'b1;
      step_out.awd_lamp = 1'b0;
      if (r.steering_turned && !r.reversing) begin
        if (steer_tmr <= HOLD_MS) begin
          if (r.tick_10ms) steer_tmr = steer_tmr + TICK_MS;
        end else begin
          ready = 1'b1;
        end
      end else begin
        steer_tmr = '0;
      end
      // cancel on speed block
      if (ready && qt_blk) begin
        step_out.qt_cancelled = 1'b1;
        qt_en = 1'b0;
        ready = 1'b0;
      end
      if (ready) begin
        if (r.tick_10ms) run_tmr = run_tmr + TICK_MS;
        if (run_tmr >= cur_cfg.qt_engage_ms) begin
          run_tmr     = cur_cfg.qt_engage_ms;
          holdoff_tmr = cur_cfg.qt_engage_ms;
          step_out.qt_valve  = 1'b1;
          flash_on           = 1'b1;
          step_out.awd_valve = 1'b0;
          step_out.awd_lamp  = 1'b0;
        end
        return;
      end
      run_tmr = '0;
    end else if (r.drive_mode == MODE_MANUAL) begin
      step_out.awd_valve = 1'b1;
      return;
    end

    // auto section, also reached from quick turn not engaged
    if (!qt_en) holdoff_tmr = '0;
    if (!step_out.qt_lamp) step_out.awd_lamp = 1'b1;
    step_out.qt_valve = 1'b0;
    if (holdoff_tmr != 0) begin
      if (r.tick_10ms) holdoff_tmr = (holdoff_tmr > TICK_MS) ? holdoff_tmr - TICK_MS : '0;
      return;
    end
    step_out.awd_valve = 1'b1;
    flash_on = 1'b0;

    // disconnect and delayed reconnect
    if (cur_cfg.awd_cutout_speed <= r.vehicle_speed) begin
      limit_on  = 1'b1;
      recon_tmr = '0;
    end else if (limit_on) begin
      if (cur_cfg.awd_reconnect_speed >= r.vehicle_speed) begin
        if (r.tick_10ms) recon_tmr = recon_tmr + TICK_MS;
        if (recon_tmr >= RECONNECT_MS) limit_on = 1'b0;
      end else begin
        recon_tmr = '0;
      end
    end

    // lamp blink pattern while speed limited
    if (r.tick_10ms) blink_tmr = blink_tmr + TICK_MS;
    if (limit_on) begin
      step_out.awd_valve = 1'b0;
      step_out.qt_valve  = 1'b0;
      if (step_out.awd_lamp) begin
        if (blink_tmr >= cur_cfg.lamp_on_ms) step_out.awd_lamp = 1'b0;
        else blink_tmr = '0;
      end
    end else begin
      blink_tmr = '0;
    end
    if (blink_tmr >= cur_cfg.lamp_cycle_ms) blink_tmr = '0;
  endfunction

  // expected outputs of one request, advancing the model
  function automatic res_t fwd_qt_step(input req_t r);
    step_out = '0;
    if (r.qt_write) qt_en = r.qt_value;
    if (!r.power_ready) begin
      qt_en       = 1'b0;
      holdoff_tmr = '0;
    end else begin
      step_body(r);
    end
    step_out.qt_flashing   = flash_on;
    step_out.qt_active     = qt_en;
    step_out.speed_limited = limit_on;
    return step_out;
  endfunction

  // offer one request, record its expected outputs when taken
  task automatic send_step(input req_t r, input logic typed, input res_t want);
    int unsigned gap;
    res_t        calc;
    gap = pick_gap(cyc[10:9] == 2'd2 || cyc[13:12] == 2'd1);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(req_t)){1'b0}}, r};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    calc = fwd_qt_step(r);
    pending_outs.push_back(typed ? want : calc);
    @(posedge clk);
  endtask

  // stop sending and wait for all outstanding results
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outs.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] mode, input logic pwr, tick, qtw, qtv, brk, sbrk,
                         input logic steer, rev, input logic [11:0] spd,
                         input logic [7:0] reps, input logic typed, input res_t want);
    step_row_t row;
    row.req = '{vehicle_speed: spd, reversing: rev, steering_turned: steer, side_brake: sbrk,
                brake_pedal: brk, qt_value: qtv, qt_write: qtw, drive_mode: mode,
                power_ready: pwr, tick_10ms: tick};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    step_table.push_back(row);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_QT_CUTOUT_SPEED:     cur_cfg.qt_cutout_speed     = val[11:0];
      REG_AWD_CUTOUT_SPEED:    cur_cfg.awd_cutout_speed    = val[11:0];
      REG_AWD_RECONNECT_SPEED: cur_cfg.awd_reconnect_speed = val[11:0];
      REG_QT_ENGAGE_MS:        cur_cfg.qt_engage_ms        = val[13:0];
      REG_LAMP_ON_MS:          cur_cfg.lamp_on_ms          = val[13:0];
      REG_LAMP_CYCLE_MS:       cur_cfg.lamp_cycle_ms       = val[13:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // register settings per phase: minimum, maximum, short timers, random
  task automatic load_settings(input int unsigned p);
    case (p)
      1: begin
        set_reg(REG_QT_CUTOUT_SPEED, 0);
        set_reg(REG_AWD_CUTOUT_SPEED, 0);
        set_reg(REG_AWD_RECONNECT_SPEED, 0);
        set_reg(REG_QT_ENGAGE_MS, 0);
        set_reg(REG_LAMP_ON_MS, 0);
        set_reg(REG_LAMP_CYCLE_MS, 0);
      end
      2: begin
        set_reg(REG_QT_CUTOUT_SPEED, 4095);
        set_reg(REG_AWD_CUTOUT_SPEED, 4095);
        set_reg(REG_AWD_RECONNECT_SPEED, 4095);
        set_reg(REG_QT_ENGAGE_MS, 10000);
        set_reg(REG_LAMP_ON_MS, 10000);
        set_reg(REG_LAMP_CYCLE_MS, 10000);
      end
      3, 5: begin
        set_reg(REG_QT_CUTOUT_SPEED, $urandom_range(20, 300));
        set_reg(REG_AWD_CUTOUT_SPEED, $urandom_range(100, 400));
        set_reg(REG_AWD_RECONNECT_SPEED, $urandom_range(20, 200));
        set_reg(REG_QT_ENGAGE_MS, 10 * $urandom_range(0, 10));
        set_reg(REG_LAMP_ON_MS, 10 * $urandom_range(0, 8));
        set_reg(REG_LAMP_CYCLE_MS, 10 * $urandom_range(1, 30));
      end
      default: begin
        set_reg(REG_QT_CUTOUT_SPEED, $urandom_range(0, 4095));
        set_reg(REG_AWD_CUTOUT_SPEED, $urandom_range(0, 4095));
        set_reg(REG_AWD_RECONNECT_SPEED, $urandom_range(0, 4095));
        set_reg(REG_QT_ENGAGE_MS, $urandom_range(0, 10000));
        set_reg(REG_LAMP_ON_MS, $urandom_range(0, 10000));
        set_reg(REG_LAMP_CYCLE_MS, $urandom_range(0, 10000));
      end
    endcase
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random idling plus a long hold-off on request
  initial begin : rx_side
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        n = pick_gap(cyc[10:9] == 2'd0 || cyc[13:12] == 2'd1);
        m_tready <= (n == 0);
        if (n > 1) repeat (n - 1) @(posedge clk);
      end
    end
  end

  // result check against the oldest expectation
  always @(negedge clk) begin : res_check
    res_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_outs.size() == 0) begin
        if (mismatches < 40) $display("%0t: unexpected result %h", $time, got);
        mismatches++;
      end else begin
        want = pending_outs.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            if (mismatches < 40)
              $display("%0t: %s expected %b actual %b", $time, out_field[i], want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin : stim
    int unsigned sent, len, kind;
    logic [1:0]  bmode;
    logic        cross_spd;
    logic [31:0] rnd;
    req_t        r;

    cur_cfg.qt_cutout_speed     = 12'd100;
    cur_cfg.awd_cutout_speed    = 12'd150;
    cur_cfg.awd_reconnect_speed = 12'd120;
    cur_cfg.qt_engage_ms        = 14'd500;
    cur_cfg.lamp_on_ms          = 14'd500;
    cur_cfg.lamp_cycle_ms       = 14'd1000;
    {qt_en, qt_blk, limit_on, flash_on} = '0;
    {blk_tmr, steer_tmr, run_tmr, holdoff_tmr, brake_tmr, recon_tmr, blink_tmr} = '0;

    // directed steps under reset settings
    //      mode         pwr tk qw qv bk sb st rv speed reps typed want
    add_row(MODE_ALT,    0,  1, 1, 1, 1, 1, 1, 1, 4095, 1,   1,    OUT_NONE); // power not ready
    add_row(MODE_MANUAL, 1,  0, 0, 0, 0, 0, 0, 0,    0, 1,   1,    OUT_AWD);  // manual holds 4WD
    add_row(MODE_OFF,    1,  1, 0, 0, 1, 1, 0, 0,    0, 1,   1,    OUT_NONE); // side brake blocks
    add_row(MODE_OFF,    1,  1, 0, 0, 1, 0, 0, 0,    0, 12,  0,    OUT_NONE); // brake held > 100 ms
    add_row(MODE_MANUAL, 1,  1, 1, 1, 0, 0, 1, 1,   50, 1,   0,    OUT_NONE); // qt on, reversing
    add_row(MODE_MANUAL, 1,  1, 0, 0, 0, 0, 1, 0,   50, 2,   0,    OUT_NONE); // steering held
    add_row(MODE_ALT,    1,  1, 1, 0, 0, 0, 0, 0, 4095, 2,   0,    OUT_NONE); // mode three cut
    add_row(MODE_AUTO,   1,  1, 0, 0, 0, 0, 0, 0,    0, 3,   0,    OUT_NONE); // reconnect wait
    add_row(MODE_AUTO,   1,  0, 0, 0, 0, 0, 0, 0,  151, 1,   0,    OUT_NONE); // cut again
    add_row(MODE_AUTO,   0,  1, 0, 0, 0, 0, 0, 0,    0, 1,   0,    OUT_NONE); // flags held
    add_row(MODE_OFF,    1,  0, 0, 0, 0, 0, 0, 0,    0, 1,   1,    OUT_NONE); // off clears all

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        foreach (step_table[i])
          repeat (step_table[i].reps)
            send_step(step_table[i].req, step_table[i].typed, step_table[i].want);
      end else begin
        load_settings(p);
      end

      // random bursts of well-formed sequences with noise between them
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        kind      = $urandom_range(0, 9);
        cross_spd = ($urandom_range(0, 3) == 0);
        case (kind)
          0, 1: begin
            bmode = MODE_OFF;
            len   = $urandom_range(5, 30);
          end
          2, 3, 4: begin
            bmode = $urandom_range(1, 3);
            len   = 12 + cur_cfg.qt_engage_ms / 10 + $urandom_range(0, 30);
            if (len > 200) len = 200;
          end
          5, 6, 7: begin
            bmode = ($urandom_range(0, 3) == 0) ? MODE_ALT : MODE_AUTO;
            len   = $urandom_range(10, 80);
          end
          default: begin
            bmode = $urandom_range(0, 3);
            len   = $urandom_range(1, 8);
          end
        endcase
        for (int k = 0; k < len && sent < RAND_PER_PHASE; k++) begin
          rnd = $urandom;
          r   = rnd[$bits(req_t)-1:0];
          r.power_ready = ($urandom_range(0, 49) != 0);
          if (kind < 8) begin
            r.drive_mode = bmode;
            r.tick_10ms  = ($urandom_range(0, 9) != 0);
            r.qt_write   = ($urandom_range(0, 24) == 0);
            r.reversing  = ($urandom_range(0, 19) == 0);
            r.side_brake = ($urandom_range(0, 19) == 0);
          end
          case (kind)
            0, 1: r.brake_pedal = ($urandom_range(0, 19) != 0);
            2, 3, 4: begin
              if (k == 0) begin
                r.qt_write = 1'b1;
                r.qt_value = 1'b1;
              end
              r.steering_turned = ($urandom_range(0, 19) != 0);
              if (cross_spd && k > len / 2)
                r.vehicle_speed = near_speed();
              else if (cur_cfg.qt_cutout_speed != 0)
                r.vehicle_speed = $urandom_range(0, cur_cfg.qt_cutout_speed - 1);
            end
            5, 6, 7: r.vehicle_speed = near_speed();
            default: ;
          endcase
          // long result hold-off while requests keep coming, then a full pause
          if (sent == HOLD_AT) hold_ask = 1'b1;
          if (sent == PAUSE_AT) drain();
          send_step(r, 1'b0, OUT_NONE);
          sent++;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("four_wheel_drive_quick_turn_ctrl test passed");
    end else begin
      $display("four_wheel_drive_quick_turn_ctrl test failed");
    end
    $finish;
  end

endmodule
